FILE: sv/apst_pkg.sv
// Shared types and constants for the audio packet sequence tracker.
`timescale 1ns / 1ps

package apst_pkg;

    localparam logic [15:0] FIFO_BYTES  = 16'd8192;
    localparam logic [11:0] MAX_PAYLOAD = 12'd2047;
    localparam logic [10:0] HDR_BYTES   = 11'd4;
    localparam logic [10:0] FB_BYTES    = 11'd4;

    localparam int DIV_STEPS = 14;

    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_FORGET  = 2'd1;
    localparam logic [1:0] CMD_RESYNC  = 2'd2;

    localparam logic [7:0] PT_SPEAKER_AUDIO = 8'd0;
    localparam logic [7:0] PT_FEEDBACK = 8'd2;
    localparam logic [7:0] PT_TEST_DN  = 8'd4;
    localparam logic [7:0] PT_TEST_UP  = 8'd5;

    localparam logic [2:0] MODE_HEADSET_AUDIO = 3'd1;
    localparam logic [2:0] MODE_DONGLE_AUDIO  = 3'd2;
    localparam logic [2:0] MODE_DONGLE_TONE   = 3'd3;
    localparam logic [2:0] MODE_DONGLE_TEST   = 3'd4;
    localparam logic [2:0] MODE_HEADSET_TEST  = 3'd5;

    typedef enum logic [2:0] {
        ACT_IGNORE   = 3'd0,
        ACT_LATE     = 3'd1,
        ACT_OVERFLOW = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_FEEDBACK = 3'd4,
        ACT_TEST_DN  = 3'd5,
        ACT_TEST_UP  = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_OUT  = 2'd2
    } t_state;

endpackage

FILE: sv/apst_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module apst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [13:0] i_dividend,
    input  logic [10:0] i_divisor,
    output logic        o_done,
    output logic [13:0] o_quot
);
    import apst_pkg::*;

    logic [13:0] r_quo;
    logic [11:0] r_rem;
    logic [10:0] r_div;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [11:0] w_trial;
    logic        w_ge;
    logic [11:0] n_rem;
    logic [13:0] n_quo;

    always_comb begin
        w_trial = {r_rem[10:0], r_quo[13]};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
        n_quo   = {r_quo[12:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: sv/audio_packet_sequence_tracker.sv
// Top level of the audio packet sequence tracker.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_ready    i_cmd .. i_first_word
// output    o_valid / i_ready    o_action .. o_peer_valid
// config    i_cfg_we             i_cfg_data (link mode)
//
// An item is taken when the block is idle. A write of audio that fills a gap
// runs the serial divider first; every other item goes straight to the output.
// The result then stays until it is taken; only after that is a new item taken.
// Reset is synchronous and clears the link mode, sequence sync and peer state.
module audio_packet_sequence_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_pkt_type,
    input  logic [15:0] i_seq_num,
    input  logic [10:0] i_payload_len,
    input  logic [47:0] i_src_mac,
    input  logic [13:0] i_fifo_space,
    input  logic [31:0] i_first_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [13:0] o_silence_count,
    output logic [10:0] o_body_len,
    output logic [15:0] o_seq_out,
    output logic [31:0] o_feedback_value,
    output logic        o_peer_learned,
    output logic [47:0] o_peer_addr,
    output logic        o_peer_valid
);
    import apst_pkg::*;

    t_state      r_state, n_state;
    logic [2:0]  r_mode;
    logic [15:0] r_exp_seq;
    logic        r_synced;
    logic [47:0] r_peer_mac;
    logic        r_peer_known;

    t_action     r_action;
    logic [13:0] r_silence;
    logic [10:0] r_dlen;
    logic [15:0] r_seq_out;
    logic [31:0] r_fb;
    logic        r_learned;
    logic [14:0] r_diff;

    logic        w_accept;
    logic        w_div_done;
    logic [13:0] w_quot;

    t_action     c_action;
    logic [10:0] c_dlen;
    logic [15:0] c_seq_out;
    logic [31:0] c_fb;
    logic        c_learn;
    logic        c_need_div;
    logic [13:0] c_space;
    logic [13:0] c_dividend;
    logic [15:0] c_exp_eff;
    logic [15:0] c_diff;
    logic        c_plen_ok;
    logic [15:0] n_exp_seq;
    logic        n_synced;
    logic        n_peer_known;
    logic        n_forget;
    logic [13:0] c_silence_div;

    assign w_accept = (r_state == ST_IDLE) && i_valid;

    always_comb begin
        c_action   = ACT_IGNORE;
        c_dlen     = '0;
        c_seq_out  = '0;
        c_fb       = '0;
        c_learn    = 1'b0;
        c_need_div = 1'b0;
        n_exp_seq  = r_exp_seq;
        n_synced   = r_synced;
        n_forget   = 1'b0;

        c_space = ({2'b0, i_fifo_space} > FIFO_BYTES) ? FIFO_BYTES[13:0] : i_fifo_space;
        c_exp_eff  = r_synced ? r_exp_seq : i_seq_num;
        c_diff     = i_seq_num - c_exp_eff;
        c_dividend = c_space - {3'b0, i_payload_len - HDR_BYTES};
        c_plen_ok  = (i_payload_len >= HDR_BYTES) && ({1'b0, i_payload_len} <= MAX_PAYLOAD);

        if (i_cmd == CMD_FORGET) begin
            n_forget = 1'b1;
        end else if (i_cmd == CMD_RESYNC) begin
            n_exp_seq = '0;
            n_synced  = 1'b0;
        end else if (i_cmd == CMD_PACKET && c_plen_ok) begin
            c_dlen = i_payload_len - HDR_BYTES;
            priority if (i_pkt_type == PT_SPEAKER_AUDIO) begin
                if (r_mode == MODE_HEADSET_AUDIO) begin
                    c_learn   = 1'b1;
                    n_synced  = 1'b1;
                    n_exp_seq = c_exp_eff;
                    priority if (c_diff[15]) begin
                        c_action = ACT_LATE;
                    end else if (c_space < {3'b0, c_dlen}) begin
                        c_action  = ACT_OVERFLOW;
                        n_exp_seq = i_seq_num + 16'd1;
                    end else begin
                        c_action   = ACT_WRITE;
                        n_exp_seq  = i_seq_num + 16'd1;
                        c_need_div = (c_diff != 16'd0) && (c_dlen != 11'd0);
                    end
                end
            end else if (i_pkt_type == PT_FEEDBACK) begin
                if (r_mode == MODE_DONGLE_AUDIO || r_mode == MODE_DONGLE_TONE) begin
                    c_learn = 1'b1;
                    if (c_dlen >= FB_BYTES && r_mode == MODE_DONGLE_AUDIO) begin
                        c_action = ACT_FEEDBACK;
                        c_fb     = i_first_word;
                    end
                end
            end else if (i_pkt_type == PT_TEST_DN) begin
                if (r_mode == MODE_HEADSET_TEST) begin
                    c_learn   = 1'b1;
                    c_action  = ACT_TEST_DN;
                    c_seq_out = i_seq_num;
                end
            end else if (i_pkt_type == PT_TEST_UP) begin
                if (r_mode == MODE_DONGLE_TEST) begin
                    c_learn   = 1'b1;
                    c_action  = ACT_TEST_UP;
                    c_seq_out = i_seq_num;
                end
            end else begin
                c_learn = 1'b0;
            end
        end

        n_peer_known = r_peer_known;
        if (n_forget) begin
            n_peer_known = 1'b0;
        end else if (c_learn) begin
            n_peer_known = 1'b1;
        end
    end

    apst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && c_need_div),
        .i_dividend (c_dividend),
        .i_divisor  (c_dlen),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign c_silence_div = ({1'b0, w_quot} > r_diff) ? r_diff[13:0] : w_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = c_need_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= '0;
            r_exp_seq    <= '0;
            r_synced     <= 1'b0;
            r_peer_mac   <= '0;
            r_peer_known <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (w_accept) begin
                r_exp_seq    <= n_exp_seq;
                r_synced     <= n_synced;
                r_peer_known <= n_peer_known;
                if (c_learn && !r_peer_known) begin
                    r_peer_mac <= i_src_mac;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= c_action;
            r_silence <= '0;
            r_dlen    <= c_dlen;
            r_seq_out <= c_seq_out;
            r_fb      <= c_fb;
            r_learned <= c_learn && !r_peer_known;
            r_diff    <= c_diff[14:0];
        end else if (r_state == ST_DIV && w_div_done) begin
            r_silence <= c_silence_div;
        end
    end

    assign o_action         = r_action;
    assign o_silence_count  = r_silence;
    assign o_body_len       = r_dlen;
    assign o_seq_out        = r_seq_out;
    assign o_feedback_value = r_fb;
    assign o_peer_learned   = r_learned;
    assign o_peer_addr      = r_peer_mac;
    assign o_peer_valid     = r_peer_known;

endmodule

FILE: sim/audio_packet_sequence_tracker_tb.sv
// Self-checking testbench for the audio packet sequence tracker.
`timescale 1ns / 1ps

module audio_packet_sequence_tracker_tb;

    import apst_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] MODE_OTHER      = 3'd0;
    localparam logic [2:0] MODE_SPARE_LO   = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI   = 3'd7;
    localparam int         CYCLE_LIMIT     = 800000;
    localparam int         SETTLE_CYCLES   = 20;
    localparam int         ITEMS_PER_PHASE = 550;

    typedef struct {
        logic [1:0]  cmd;
        logic [7:0]  pkt_type;
        logic [15:0] seq;
        logic [10:0] len;
        logic [47:0] mac;
        logic [13:0] space;
        logic [31:0] word;
    } t_pkt_hdr;

    typedef struct {
        t_action     action;
        logic [13:0] silence;
        logic [10:0] dlen;
        logic [15:0] seq_out;
        logic [31:0] fb;
        logic        learned;
        logic [47:0] peer_addr;
        logic        peer_valid;
    } t_decision;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_pkt_type;
    logic [15:0] i_seq_num;
    logic [10:0] i_payload_len;
    logic [47:0] i_src_mac;
    logic [13:0] i_fifo_space;
    logic [31:0] i_first_word;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_action;
    logic [13:0] o_silence_count;
    logic [10:0] o_body_len;
    logic [15:0] o_seq_out;
    logic [31:0] o_feedback_value;
    logic        o_peer_learned;
    logic [47:0] o_peer_addr;
    logic        o_peer_valid;

    logic [2:0]  trk_mode;
    logic [15:0] trk_exp_seq;
    logic        trk_synced;
    logic [47:0] trk_peer_mac;
    logic        trk_peer_known;

    t_decision   pending_decisions[$];
    logic [47:0] last_mac;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold;
    int          mismatch_count;

    audio_packet_sequence_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_pkt_type      (i_pkt_type),
        .i_seq_num       (i_seq_num),
        .i_payload_len   (i_payload_len),
        .i_src_mac       (i_src_mac),
        .i_fifo_space    (i_fifo_space),
        .i_first_word    (i_first_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_silence_count (o_silence_count),
        .o_body_len      (o_body_len),
        .o_seq_out       (o_seq_out),
        .o_feedback_value(o_feedback_value),
        .o_peer_learned  (o_peer_learned),
        .o_peer_addr     (o_peer_addr),
        .o_peer_valid    (o_peer_valid)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic learn_peer(logic [47:0] mac);
        if (trk_peer_known) begin
            return 1'b0;
        end
        trk_peer_mac   = mac;
        trk_peer_known = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_decision predict_decision(t_pkt_hdr p);
        t_decision   d;
        int unsigned room;
        int unsigned dlen;
        int unsigned ins;
        logic [15:0] gap;
        d.action  = ACT_IGNORE;
        d.silence = '0;
        d.dlen    = '0;
        d.seq_out = '0;
        d.fb      = '0;
        d.learned = 1'b0;
        room = (p.space > FIFO_BYTES) ? FIFO_BYTES : p.space;
        if (p.cmd == CMD_FORGET) begin
            trk_peer_known = 1'b0;
        end else if (p.cmd == CMD_RESYNC) begin
            trk_exp_seq = '0;
            trk_synced  = 1'b0;
        end else if (p.cmd == CMD_PACKET && p.len >= HDR_BYTES && p.len <= MAX_PAYLOAD) begin
            dlen   = p.len - HDR_BYTES;
            d.dlen = 11'(dlen);
            case (p.pkt_type)
                PT_SPEAKER_AUDIO: begin
                    if (trk_mode == MODE_HEADSET_AUDIO) begin
                        d.learned = learn_peer(p.mac);
                        if (!trk_synced) begin
                            trk_exp_seq = p.seq;
                            trk_synced  = 1'b1;
                        end
                        gap = p.seq - trk_exp_seq;
                        if (gap[15]) begin
                            d.action = ACT_LATE;
                        end else if (room < dlen) begin
                            d.action    = ACT_OVERFLOW;
                            trk_exp_seq = p.seq + 16'd1;
                        end else begin
                            if (gap != 0 && dlen != 0) begin
                                ins = (room - dlen) / dlen;
                                if (ins > gap) begin
                                    ins = gap;
                                end
                                d.silence = 14'(ins);
                            end
                            d.action    = ACT_WRITE;
                            trk_exp_seq = p.seq + 16'd1;
                        end
                    end
                end
                PT_FEEDBACK: begin
                    if (trk_mode == MODE_DONGLE_AUDIO || trk_mode == MODE_DONGLE_TONE) begin
                        d.learned = learn_peer(p.mac);
                        if (dlen >= FB_BYTES && trk_mode == MODE_DONGLE_AUDIO) begin
                            d.action = ACT_FEEDBACK;
                            d.fb     = p.word;
                        end
                    end
                end
                PT_TEST_DN: begin
                    if (trk_mode == MODE_HEADSET_TEST) begin
                        d.learned = learn_peer(p.mac);
                        d.action  = ACT_TEST_DN;
                        d.seq_out = p.seq;
                    end
                end
                PT_TEST_UP: begin
                    if (trk_mode == MODE_DONGLE_TEST) begin
                        d.learned = learn_peer(p.mac);
                        d.action  = ACT_TEST_UP;
                        d.seq_out = p.seq;
                    end
                end
                default: ;
            endcase
        end
        d.peer_addr  = trk_peer_mac;
        d.peer_valid = trk_peer_known;
        return d;
    endfunction

    function automatic t_pkt_hdr mk_pkt(logic [1:0] cmd, logic [7:0] pkt_type,
                                        logic [15:0] seq, logic [10:0] len,
                                        logic [47:0] mac, logic [13:0] space,
                                        logic [31:0] word);
        t_pkt_hdr p;
        p.cmd      = cmd;
        p.pkt_type = pkt_type;
        p.seq      = seq;
        p.len      = len;
        p.mac      = mac;
        p.space    = space;
        p.word     = word;
        return p;
    endfunction

    function automatic logic [7:0] pick_known_type();
        case ($urandom_range(0, 3))
            0:       return PT_SPEAKER_AUDIO;
            1:       return PT_FEEDBACK;
            2:       return PT_TEST_DN;
            default: return PT_TEST_UP;
        endcase
    endfunction

    function automatic t_pkt_hdr gen_packet();
        t_pkt_hdr p;
        int       r;
        p.cmd  = CMD_PACKET;
        p.seq  = 16'($urandom);
        p.word = $urandom;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            p.cmd = CMD_FORGET;
        end else if (r < 6) begin
            p.cmd = CMD_RESYNC;
        end else if (r < 7) begin
            p.cmd = CMD_UNUSED;
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            case (trk_mode)
                MODE_HEADSET_AUDIO: p.pkt_type = PT_SPEAKER_AUDIO;
                MODE_DONGLE_AUDIO:  p.pkt_type = PT_FEEDBACK;
                MODE_DONGLE_TONE:   p.pkt_type = PT_FEEDBACK;
                MODE_DONGLE_TEST:   p.pkt_type = PT_TEST_UP;
                MODE_HEADSET_TEST:  p.pkt_type = PT_TEST_DN;
                default:            p.pkt_type = pick_known_type();
            endcase
        end else if (r < 90) begin
            p.pkt_type = pick_known_type();
        end else begin
            p.pkt_type = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            p.len = 11'($urandom_range(0, 3));
        end else if (r < 10) begin
            p.len = 11'd2047;
        end else if (r < 15) begin
            p.len = 11'($urandom);
        end else if (r < 25) begin
            p.len = 11'($urandom_range(4, 11));
        end else begin
            p.len = 11'($urandom_range(4, 600));
        end
        r = $urandom_range(0, 99);
        if (r < 10) begin
            p.space = 14'($urandom_range(8193, 16383));
        end else if (r < 20) begin
            p.space = 14'($urandom_range(0, p.len));
        end else if (r < 25) begin
            p.space = 14'($urandom);
        end else begin
            p.space = 14'($urandom_range(0, 8192));
        end
        if (p.pkt_type == PT_SPEAKER_AUDIO) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                p.seq = trk_exp_seq;
            end else if (r < 70) begin
                p.seq = trk_exp_seq + 16'($urandom_range(1, 3));
            end else if (r < 80) begin
                p.seq = trk_exp_seq + 16'($urandom_range(4, 60));
            end else if (r < 90) begin
                p.seq = trk_exp_seq - 16'($urandom_range(1, 20));
            end else if (r < 95) begin
                p.seq = 16'($urandom);
            end else begin
                p.seq = trk_exp_seq + 16'($urandom_range(32767, 32768));
            end
        end
        if ($urandom_range(0, 1) == 0) begin
            last_mac = {16'($urandom), 32'($urandom)};
        end
        p.mac = last_mac;
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_item(input t_pkt_hdr p);
        t_decision d;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_cmd         = p.cmd;
        i_pkt_type    = p.pkt_type;
        i_seq_num     = p.seq;
        i_payload_len = p.len;
        i_src_mac     = p.mac;
        i_fifo_space  = p.space;
        i_first_word  = p.word;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        d = predict_decision(p);
        pending_decisions.push_back(d);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_link_mode(input logic [2:0] mode);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = mode;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        trk_mode = mode;
    endtask

    task automatic test_directed();
        logic [47:0] mac_a;
        logic [47:0] mac_b;
        mac_a = 48'h0012_3456_789A;
        mac_b = 48'h00AB_CDEF_0123;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd5, 11'd100, mac_a,
                         14'd8192, 32'd0));
        set_link_mode(MODE_HEADSET_AUDIO);
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd100, 11'd404, mac_a,
                         14'd8192, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd103, 11'd104, mac_b,
                         14'd16383, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd101, 11'd104, mac_b,
                         14'd8192, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd104, 11'd2047, mac_b,
                         14'd100, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd110, 11'd4, mac_b,
                         14'd0, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd111, 11'd3, mac_b,
                         14'd8192, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd111, 11'd0, mac_b,
                         14'd8192, 32'd0));
        send_item(mk_pkt(CMD_PACKET, 8'hFF, 16'd111, 11'd100, mac_b, 14'd8192, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_FEEDBACK, 16'd111, 11'd100, mac_b, 14'd8192, 32'd0));
        send_item(mk_pkt(CMD_FORGET, 8'd0, 16'd0, 11'd0, 48'd0, 14'd0, 32'd0));
        send_item(mk_pkt(CMD_UNUSED, PT_SPEAKER_AUDIO, 16'd111, 11'd100, mac_b,
                         14'd8192, 32'd0));
        send_item(mk_pkt(CMD_RESYNC, 8'd0, 16'd0, 11'd0, 48'd0, 14'd0, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'hFFFF, 11'd2047, '1,
                         14'd0, 32'hFFFF_FFFF));
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd0, 11'd2047, mac_a,
                         14'd8192, 32'd0));
        set_link_mode(MODE_DONGLE_AUDIO);
        send_item(mk_pkt(CMD_PACKET, PT_FEEDBACK, 16'd7, 11'd8, mac_a, 14'd0, 32'hFFFF_FFFF));
        send_item(mk_pkt(CMD_PACKET, PT_FEEDBACK, 16'd8, 11'd7, mac_a, 14'd0, 32'h0001_8000));
        send_item(mk_pkt(CMD_PACKET, PT_TEST_DN, 16'd9, 11'd8, mac_a, 14'd0, 32'd0));
        set_link_mode(MODE_DONGLE_TONE);
        send_item(mk_pkt(CMD_FORGET, 8'd0, 16'd0, 11'd0, 48'd0, 14'd0, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_FEEDBACK, 16'd1, 11'd2047, 48'd0, 14'd0, 32'h1234));
        set_link_mode(MODE_DONGLE_TEST);
        send_item(mk_pkt(CMD_PACKET, PT_TEST_UP, 16'hFFFF, 11'd64, mac_b, 14'd0, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_TEST_DN, 16'd3, 11'd64, mac_b, 14'd0, 32'd0));
        set_link_mode(MODE_HEADSET_TEST);
        send_item(mk_pkt(CMD_PACKET, PT_TEST_DN, 16'd0, 11'd4, mac_b, 14'd0, 32'd0));
        send_item(mk_pkt(CMD_PACKET, PT_TEST_UP, 16'd2, 11'd4, mac_b, 14'd0, 32'd0));
        set_link_mode(MODE_SPARE_LO);
        send_item(mk_pkt(CMD_PACKET, PT_SPEAKER_AUDIO, 16'd1, 11'd100, mac_a,
                         14'd8192, 32'd0));
        set_link_mode(MODE_SPARE_HI);
        send_item(mk_pkt(CMD_PACKET, PT_TEST_DN, 16'd1, 11'd100, mac_a, 14'd8192, 32'd0));
        set_link_mode(MODE_OTHER);
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
        int          counted;
        int          seg_len;
        int          r;
        logic [2:0]  mode;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        counted     = 0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                mode = MODE_HEADSET_AUDIO;
            end else if (r < 55) begin
                mode = MODE_DONGLE_AUDIO;
            end else if (r < 65) begin
                mode = MODE_DONGLE_TONE;
            end else if (r < 75) begin
                mode = MODE_DONGLE_TEST;
            end else if (r < 85) begin
                mode = MODE_HEADSET_TEST;
            end else begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_OTHER;
                    1:       mode = MODE_SPARE_LO;
                    default: mode = MODE_SPARE_HI;
                endcase
            end
            set_link_mode(mode);
            seg_len = $urandom_range(30, 90);
            for (int i = 0; i < seg_len && counted < n_items; i++) begin
                send_item(gen_packet());
                counted++;
            end
        end
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_link_mode(MODE_HEADSET_AUDIO);
        @(posedge i_clk);
        rx_hold = 300;
        for (int i = 0; i < 40; i++) begin
            send_item(gen_packet());
        end
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_ready = 1'b0;
            rx_hold--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_decision d;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                d = pending_decisions.pop_front();
                if (o_action !== d.action)
                    report_mismatch($sformatf("action %0d, want %0d", o_action, d.action));
                if (o_silence_count !== d.silence)
                    report_mismatch($sformatf("silence_count %0d, want %0d",
                                              o_silence_count, d.silence));
                if (o_body_len !== d.dlen)
                    report_mismatch($sformatf("body_len %0d, want %0d", o_body_len, d.dlen));
                if (o_seq_out !== d.seq_out)
                    report_mismatch($sformatf("seq_out %h, want %h", o_seq_out, d.seq_out));
                if (o_feedback_value !== d.fb)
                    report_mismatch($sformatf("feedback_value %h, want %h",
                                              o_feedback_value, d.fb));
                if (o_peer_learned !== d.learned)
                    report_mismatch($sformatf("peer_learned %b, want %b",
                                              o_peer_learned, d.learned));
                if (o_peer_addr !== d.peer_addr)
                    report_mismatch($sformatf("peer_addr %h, want %h",
                                              o_peer_addr, d.peer_addr));
                if (o_peer_valid !== d.peer_valid)
                    report_mismatch($sformatf("peer_valid %b, want %b",
                                              o_peer_valid, d.peer_valid));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_cmd          = '0;
        i_pkt_type     = '0;
        i_seq_num      = '0;
        i_payload_len  = '0;
        i_src_mac      = '0;
        i_fifo_space   = '0;
        i_first_word   = '0;
        trk_mode       = MODE_OTHER;
        trk_exp_seq    = '0;
        trk_synced     = 1'b0;
        trk_peer_mac   = '0;
        trk_peer_known = 1'b0;
        last_mac       = '0;
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        rx_hold        = 0;
        mismatch_count = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_phase(6, 85, ITEMS_PER_PHASE);
        test_random_phase(85, 6, ITEMS_PER_PHASE);
        test_output_stall();
        test_random_phase(0, 0, ITEMS_PER_PHASE);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/apst_pkg.sv
sv/apst_div.sv
sv/audio_packet_sequence_tracker.sv
sim/audio_packet_sequence_tracker_tb.sv
